>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the deframer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define TFDD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion on the block's own clock and reset.
`define TFDD_ASSERT_DEF(lbl, prop, msg) \
  `TFDD_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/tfdd_pkg.sv
// ---------------------------------------------------------------------------
// tfdd_pkg
// Types and constants shared by the telemetry deframer and decoder.
// ---------------------------------------------------------------------------
package tfdd_pkg;

  localparam int unsigned InW  = 8;
  localparam int unsigned OutW = 88;

  localparam logic [7:0] FlagByte   = 8'h7E;
  localparam logic [7:0] EscByte    = 8'h7D;
  localparam logic [7:0] EscMask    = 8'h20;
  localparam logic [7:0] DataFrame  = 8'h10;
  localparam logic [7:0] SumGood    = 8'hFF;
  localparam logic [3:0] LastIdx    = 4'd8;

  localparam logic [15:0] AppAlt    = 16'h0100;
  localparam logic [7:0]  OldIdMax  = 8'h3F;
  localparam logic [7:0]  IdBaroAlt = 8'h21;
  localparam logic [7:0]  IdGpsAlt  = 8'h09;
  localparam logic [7:0]  IdLonWhl  = 8'h12;
  localparam logic [7:0]  IdLonFrc  = 8'h1A;
  localparam logic [7:0]  IdLatWhl  = 8'h13;
  localparam logic [7:0]  IdLatFrc  = 8'h1B;
  localparam logic [7:0]  IdLonHem  = 8'h22;
  localparam logic [7:0]  IdLatHem  = 8'h23;
  localparam logic [15:0] CharEast  = 16'h0045;
  localparam logic [15:0] CharNorth = 16'h004E;

  localparam int unsigned FlgLatSouth = 0;
  localparam int unsigned FlgLonWest  = 1;
  localparam int unsigned FlgFix      = 2;
  localparam int unsigned FlgLatSeen  = 3;
  localparam int unsigned FlgLonSeen  = 4;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhFrame = 2'd1,
    PhEsc   = 2'd2
  } phase_e;

  typedef struct packed {
    logic        done;
    logic        ok;
    logic        is_data;
    logic [15:0] app;
    logic [15:0] value;
  } frame_t;

  typedef struct packed {
    logic [4:0]  flags;
    logic [15:0] lon_frac;
    logic [15:0] lon_whole;
    logic [15:0] lat_frac;
    logic [15:0] lat_whole;
    logic [15:0] altitude;
  } telem_t;

endpackage

>>> rtl/tfdd_deframer.sv
// ---------------------------------------------------------------------------
// tfdd_deframer
// Byte unstuffing, frame assembly and running end-around-carry checksum.
// ---------------------------------------------------------------------------
module tfdd_deframer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [tfdd_pkg::InW-1:0] byte_i,
  output tfdd_pkg::frame_t       frame_o
);
  import tfdd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] app_q, app_d;
  logic [15:0] value_q, value_d;
  logic        store;
  logic [7:0]  data;
  logic [7:0]  sum_next;

  function automatic logic [7:0] fold_add(input logic [7:0] s, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    return t[7:0] + {7'd0, t[8]};
  endfunction

  assign sum_next = fold_add(sum_q, data);

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    sum_d   = sum_q;
    type_d  = type_q;
    app_d   = app_q;
    value_d = value_q;
    store   = 1'b0;
    data    = byte_i;
    frame_o = '0;
    if (byte_i == FlagByte) begin
      phase_d = PhFrame;
      count_d = '0;
      sum_d   = '0;
    end else begin
      unique case (phase_q)
        PhEsc: begin
          data    = byte_i ^ EscMask;
          store   = 1'b1;
          phase_d = PhFrame;
        end
        PhFrame: begin
          if (byte_i == EscByte) begin
            phase_d = PhEsc;
          end else begin
            store = 1'b1;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
    if (store) begin
      count_d = count_q + 4'd1;
      if (count_q != 4'd0) begin
        sum_d = sum_next;
      end
      unique case (count_q)
        4'd1:    type_d        = data;
        4'd2:    app_d[7:0]    = data;
        4'd3:    app_d[15:8]   = data;
        4'd4:    value_d[7:0]  = data;
        4'd5:    value_d[15:8] = data;
        default: ;
      endcase
      if (count_q == LastIdx) begin
        phase_d         = PhIdle;
        count_d         = '0;
        frame_o.done    = 1'b1;
        frame_o.ok      = (sum_next == SumGood);
        frame_o.is_data = (type_q == DataFrame);
        frame_o.app     = app_q;
        frame_o.value   = value_q;
      end
    end
    if (!step_i) begin
      frame_o.done = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      count_q <= '0;
      sum_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      type_q  <= type_d;
      app_q   <= app_d;
      value_q <= value_d;
    end
  end

endmodule

>>> rtl/tfdd_decoder.sv
// ---------------------------------------------------------------------------
// tfdd_decoder
// Applies decoded telemetry values to the altitude, position and flag state.
// ---------------------------------------------------------------------------
module tfdd_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             vario_mode_i,
  input  tfdd_pkg::frame_t frame_i,
  output tfdd_pkg::telem_t telem_o
);
  import tfdd_pkg::*;

  telem_t      st_q, st_d;
  logic [22:0] baro_prod;
  logic [15:0] v;

  assign v         = frame_i.value;
  assign baro_prod = {7'd0, v} * 23'd100;

  always_comb begin
    st_d = st_q;
    if (frame_i.done && frame_i.ok && frame_i.is_data) begin
      if (frame_i.app[15:8] == 8'd0) begin
        if (frame_i.app[7:0] <= OldIdMax) begin
          unique case (frame_i.app[7:0])
            IdBaroAlt: if (vario_mode_i) st_d.altitude = baro_prod[15:0];
            IdGpsAlt:  if (!vario_mode_i) st_d.altitude = v;
            IdLonWhl: begin
              st_d.flags[FlgFix] = (v != 16'd0);
              st_d.lon_whole     = v;
            end
            IdLonFrc:  st_d.lon_frac = v;
            IdLatWhl: begin
              st_d.flags[FlgFix] = (v != 16'd0);
              st_d.lat_whole     = v;
            end
            IdLatFrc:  st_d.lat_frac = v;
            IdLonHem: begin
              st_d.flags[FlgLonWest] = (v != CharEast);
              st_d.flags[FlgLonSeen] = 1'b1;
            end
            IdLatHem: begin
              st_d.flags[FlgLatSouth] = (v != CharNorth);
              st_d.flags[FlgLatSeen]  = 1'b1;
            end
            default: ;
          endcase
        end
      end else if (frame_i.app == AppAlt) begin
        st_d.altitude = v;
      end
    end
  end

  assign telem_o = st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

>>> rtl/telemetry_frame_deframer_decoder_top.sv
// ---------------------------------------------------------------------------
// telemetry_frame_deframer_decoder_top
// Byte-stuffed telemetry deframer with checksum and value decoder.
// ---------------------------------------------------------------------------
// The slave stream takes one received serial byte per request in tdata.
// Bytes are unstuffed and collected into nine-byte frames; each completed
// frame gives one request on the master stream, other bytes give none.
// Master tuser carries the checksum result, tdata the altitude, position
// parts and flags after the frame has been applied.
// A byte is registered in the input register on acceptance and processed from
// there; a frame's result is registered in the result register before it is offered.
// One byte is accepted every cycle while the result register is free or
// being emptied; the single result register sets this figure.
// If the receiver stalls with a result waiting, the next byte is held in
// the input register and slave tready falls until the result is taken.
// The configuration write selects the altitude source and is taken at once.
// Reset clears the frame phase, count and checksum, all decoded values and both stream valid flags.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module telemetry_frame_deframer_decoder_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,    // vario_mode
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [tfdd_pkg::InW-1:0] s_axis_tdata,   // rx_byte
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // altitude, lat_whole, lat_frac, lon_whole, lon_frac, lat_south, lon_west,
  // fix_seen, lat_seen, lon_seen, three zero bits
  output logic [tfdd_pkg::OutW-1:0] m_axis_tdata,
  output logic                     m_axis_tuser    // sum_ok
);
  import tfdd_pkg::*;

  logic           vario_q;
  logic           in_valid_q, in_valid_d;
  logic [InW-1:0] in_byte_q;
  logic           in_accept;
  logic           advance;
  logic           out_valid_q, out_valid_d;
  logic           out_ok_q;
  telem_t         out_q;
  frame_t         frame;
  telem_t         telem;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && frame.done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  tfdd_deframer u_deframer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_byte_q),
    .frame_o (frame)
  );

  tfdd_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .vario_mode_i (vario_q),
    .frame_i      (frame),
    .telem_o      (telem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vario_q     <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vario_q <= cfg_wdata_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && frame.done) begin
      out_q    <= telem;
      out_ok_q <= frame.ok;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {3'b000, out_q};

  `TFDD_ASSERT_DEF(a_result_from_byte, (out_valid_q && !$past(out_valid_q)) |-> $past(in_valid_q), "result without a processed byte")
  `TFDD_ASSERT_DEF(a_byte_kept, (in_valid_q && !advance) |=> in_valid_q, "pending byte lost while stalled")
  `TFDD_ASSERT_DEF(a_ready_when_empty, !s_axis_tready |-> (in_valid_q && out_valid_q), "input stalled without cause")

endmodule
